/* hdl/lbp_pkg.sv */
package lbp_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 16;
  localparam int ROW_W = 16;
  localparam int IMG_W_W = 11;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam logic [IMG_W_W-1:0] WIDTH_RESET = IMG_W_W'(640);
  localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);

  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic emit;
    logic frame_last;
  } pos_t;

  function automatic logic [PIX_W-1:0] lbp_code_f(input win_t win);
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] code;
    ctr = win[4];
    code[7] = win[0] >= ctr;
    code[6] = win[1] >= ctr;
    code[5] = win[2] >= ctr;
    code[4] = win[5] >= ctr;
    code[3] = win[8] >= ctr;
    code[2] = win[7] >= ctr;
    code[1] = win[6] >= ctr;
    code[0] = win[3] >= ctr;
    return code;
  endfunction

endpackage

/* hdl/lbp_line_buf.sv */
module lbp_line_buf import lbp_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [PIX_W-1:0] wr_pix_i,
  output logic [PIX_W-1:0] top_o,
  output logic [PIX_W-1:0] mid_o
);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_q;
  logic [PIX_W-1:0] mid_q;

  // The row one above moves up into the upper store as the new pixel replaces it.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i] <= mid_q;
      middle_mem[wr_addr_i] <= wr_pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      top_q <= upper_mem[rd_addr_i];
      mid_q <= middle_mem[rd_addr_i];
    end
  end

  assign top_o = top_q;
  assign mid_o = mid_q;

endmodule

/* hdl/lbp_pos_ctrl.sv */
module lbp_pos_ctrl import lbp_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             accept_i,
  output logic [AW-1:0]    col_o,
  output pos_t             pos_o
);

  localparam int WW = (AW + 2 > IMG_W_W + 1) ? AW + 2 : IMG_W_W + 1;

  logic [IMG_W_W-1:0] width_q;
  logic [ROW_W-1:0]   height_q;
  logic [AW-1:0]      col_q;
  logic [AW-1:0]      col_d;
  logic [ROW_W-1:0]   row_q;
  logic [ROW_W-1:0]   row_d;
  logic [WW-1:0]      w_ext;
  logic [WW-1:0]      eff_w;
  logic [WW-1:0]      col_inc;
  logic [ROW_W-1:0]   eff_h;
  logic [ROW_W:0]     row_inc;
  logic               row_end;
  logic               frame_last;

  always_comb begin
    w_ext = WW'(width_q);
    if (w_ext < WW'(3)) begin
      eff_w = WW'(3);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    eff_h = (height_q < ROW_W'(3)) ? ROW_W'(3) : height_q;
    col_inc = WW'(col_q) + WW'(1);
    row_inc = {1'b0, row_q} + (ROW_W + 1)'(1);
    row_end = col_inc >= eff_w;
    frame_last = row_end && (row_inc >= {1'b0, eff_h});
    col_d = row_end ? '0 : col_inc[AW-1:0];
    row_d = frame_last ? '0 : (row_end ? row_inc[ROW_W-1:0] : row_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH: width_q <= cfg_wdata_i[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o = col_q;
  assign pos_o.emit = (row_q >= ROW_W'(2)) && (col_q >= AW'(2));
  assign pos_o.frame_last = frame_last;

endmodule

/* hdl/lbp_3x3_pixel_stream_top.sv */
// Each pixel passes the input register; its window's code is held in the output register.
// Throughput: one pixel per cycle; each line store has one read and one write port.
// The pixel input stalls only while a code waits in the output register and the pixel
// held in the input register would also produce a code.
// Reset clears the window, positions and handshake state; the line stores are not cleared.
module lbp_3x3_pixel_stream_top import lbp_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             pixel_valid_i,
  output logic             pixel_ready_o,
  input  logic [PIX_W-1:0] pixel_i,
  output logic             lbp_valid_o,
  input  logic             lbp_ready_i,
  output logic [PIX_W-1:0] lbp_code_o,
  output logic             frame_end_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic             accept;
  logic             s1_adv;
  logic [AW-1:0]    col;
  pos_t             pos;
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [AW-1:0]    s1_col_q;
  pos_t             s1_pos_q;
  logic [PIX_W-1:0] top_pix;
  logic [PIX_W-1:0] mid_pix;
  win_t             win_q;
  win_t             win_d;
  logic             out_valid_q;
  logic [PIX_W-1:0] code_q;
  logic             frame_end_q;

  assign accept = pixel_valid_i && pixel_ready_o;
  assign s1_adv = s1_valid_q && (!s1_pos_q.emit || !out_valid_q || lbp_ready_i);
  assign pixel_ready_o = !s1_valid_q || s1_adv;

  lbp_pos_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_pos_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .col_o      (col),
    .pos_o      (pos)
  );

  lbp_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_addr_i(col),
    .wr_en_i  (s1_adv),
    .wr_addr_i(s1_col_q),
    .wr_pix_i (s1_pix_q),
    .top_o    (top_pix),
    .mid_o    (mid_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_pos_q <= '0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_pos_q <= pos;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= pixel_i;
      s1_col_q <= col;
    end
  end

  always_comb begin
    win_d = win_q;
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = top_pix;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = mid_pix;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_pos_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (lbp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_pos_q.emit) begin
      code_q <= lbp_code_f(win_d);
      frame_end_q <= s1_pos_q.frame_last;
    end
  end

  assign lbp_valid_o = out_valid_q;
  assign lbp_code_o = code_q;
  assign frame_end_o = frame_end_q;

endmodule

/* hdl/lbp_checker.sv */
module lbp_checker import lbp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             pixel_valid_i,
  input logic             pixel_ready_o,
  input logic             lbp_valid_o,
  input logic             lbp_ready_i,
  input logic [PIX_W-1:0] lbp_code_o,
  input logic             frame_end_o
);

  // A code that has not been taken stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lbp_valid_o && !lbp_ready_i |=> lbp_valid_o && $stable(lbp_code_o) && $stable(frame_end_o))
    else $error("stalled result transaction changed");

  // With no code waiting, the pixel input is always open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lbp_valid_o |-> pixel_ready_o)
    else $error("pixel input blocked with empty output");

  // A new code must follow an accepted pixel transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(lbp_valid_o) |-> $past(pixel_valid_i && pixel_ready_o, 2))
    else $error("result transaction without a matching pixel transaction");

endmodule

bind lbp_3x3_pixel_stream_top lbp_checker u_lbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pixel_valid_i(pixel_valid_i),
  .pixel_ready_o(pixel_ready_o),
  .lbp_valid_o  (lbp_valid_o),
  .lbp_ready_i  (lbp_ready_i),
  .lbp_code_o   (lbp_code_o),
  .frame_end_o  (frame_end_o)
);

/* verif/lbp_checker.sv */
`timescale 1ns / 1ps

module lbp_scoreboard import lbp_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             pixel_valid_i,
  input  logic             pixel_ready_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             lbp_valid_i,
  input  logic             lbp_ready_i,
  input  logic [PIX_W-1:0] lbp_code_i,
  input  logic             frame_end_i,
  output int               error_count_o,
  output int               pending_o,
  output logic             frame_start_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  typedef struct packed {
    logic [PIX_W-1:0] code;
    logic             frame_end;
  } lbp_result_t;

  lbp_result_t        expected_codes[$];
  logic [PIX_W-1:0]   upper_row [MAX_WIDTH];
  logic [PIX_W-1:0]   middle_row [MAX_WIDTH];
  logic [PIX_W-1:0]   win_px [9];
  logic [IMG_W_W-1:0] width_reg;
  logic [ROW_W-1:0]   height_reg;
  int unsigned        col;
  int unsigned        row;
  int                 errors = 0;

  initial begin
    foreach (upper_row[i]) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] beside;
    logic [PIX_W-1:0] ctr;
    logic             row_end;
    logic             last;
    lbp_result_t      exp_res;
    if (!rst_ni) begin
      expected_codes.delete();
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (win_px[i]) win_px[i] = '0;
      col = 0;
      row = 0;
      pending_o <= 0;
      frame_start_o <= 1'b1;
      error_count_o <= errors;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_IMAGE_WIDTH) begin
          width_reg = cfg_wdata_i[IMG_W_W-1:0];
        end else begin
          height_reg = cfg_wdata_i[ROW_W-1:0];
        end
      end

      // A code leaves the block through the input and output registers after its pixel, so it is
      // matched before this edge's pixel adds a new expectation.
      if (lbp_valid_i && lbp_ready_i) begin
        if (expected_codes.size() == 0) begin
          $error("unexpected lbp transaction: lbp_code %0h frame_end %0b",
                 lbp_code_i, frame_end_i);
          errors++;
        end else begin
          exp_res = expected_codes.pop_front();
          if (lbp_code_i !== exp_res.code) begin
            $error("lbp_code mismatch: expected %0h, actual %0h", exp_res.code, lbp_code_i);
            errors++;
          end
          if (frame_end_i !== exp_res.frame_end) begin
            $error("frame_end mismatch: expected %0b, actual %0b",
                   exp_res.frame_end, frame_end_i);
            errors++;
          end
        end
      end

      if (pixel_valid_i && pixel_ready_i) begin
        w = 32'(width_reg);
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = 32'(height_reg);
        if (h < 3) h = 3;
        c = (col >= MAX_WIDTH) ? MAX_WIDTH - 1 : col;

        above = upper_row[c[AW-1:0]];
        beside = middle_row[c[AW-1:0]];
        upper_row[c[AW-1:0]] = beside;
        middle_row[c[AW-1:0]] = pixel_i;

        win_px[0] = win_px[1];
        win_px[1] = win_px[2];
        win_px[2] = above;
        win_px[3] = win_px[4];
        win_px[4] = win_px[5];
        win_px[5] = beside;
        win_px[6] = win_px[7];
        win_px[7] = win_px[8];
        win_px[8] = pixel_i;

        row_end = (c + 1 >= w);
        last = row_end && (row + 1 >= h);

        if (row >= 2 && c >= 2) begin
          ctr = win_px[4];
          exp_res.code = {win_px[0] >= ctr, win_px[1] >= ctr, win_px[2] >= ctr,
                          win_px[5] >= ctr, win_px[8] >= ctr, win_px[7] >= ctr,
                          win_px[6] >= ctr, win_px[3] >= ctr};
          exp_res.frame_end = last;
          expected_codes.push_back(exp_res);
        end

        if (row_end) begin
          col = 0;
          row = last ? 0 : ((row + 1) & 32'hFFFF);
        end else begin
          col = c + 1;
        end
      end

      pending_o <= expected_codes.size();
      frame_start_o <= (col == 0) && (row == 0);
      error_count_o <= errors;
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lbp_pkg::*;

  localparam int MAX_WIDTH = 1024;
  localparam int RANDOM_ITEMS = 200;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 4_000_000;

  localparam logic [8:0][PIX_W-1:0] MIXED_FRAME = {
    8'd0, 8'd255, 8'd129, 8'd128, 8'd128, 8'd0, 8'd255, 8'd128, 8'd127
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             pixel_valid_i = 1'b0;
  logic             pixel_ready_o;
  logic [PIX_W-1:0] pixel_i = '0;
  logic             lbp_valid_o;
  logic             lbp_ready_i = 1'b0;
  logic [PIX_W-1:0] lbp_code_o;
  logic             frame_end_o;

  int   error_count;
  int   pending;
  logic frame_start;
  int   hold_req = 0;
  int   cycles = 0;
  int   eff_w = int'(WIDTH_RESET);
  int   eff_h = int'(HEIGHT_RESET);

  always #5 clk_i = ~clk_i;

  lbp_3x3_pixel_stream_top #(.MAX_WIDTH(MAX_WIDTH)) uut (.*);

  lbp_scoreboard #(.MAX_WIDTH(MAX_WIDTH)) lbp_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pixel_valid_i(pixel_valid_i),
    .pixel_ready_i(pixel_ready_o),
    .pixel_i      (pixel_i),
    .lbp_valid_i  (lbp_valid_o),
    .lbp_ready_i  (lbp_ready_i),
    .lbp_code_i   (lbp_code_o),
    .frame_end_i  (frame_end_o),
    .error_count_o(error_count),
    .pending_o    (pending),
    .frame_start_o(frame_start)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] next_pixel(input int mode, input logic [PIX_W-1:0] base);
    case (mode)
      1: return base + PIX_W'($urandom_range(0, 3));
      2: return $urandom_range(0, 1) ? {PIX_W{1'b1}} : '0;
      3: return ($urandom_range(0, 7) == 0) ? PIX_W'($urandom_range(0, 255)) : base;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit dense, input int min_gap);
    int gap;
    pixel_valid_i <= 1'b1;
    pixel_i <= px;
    @(posedge clk_i);
    while (!pixel_ready_o) @(posedge clk_i);
    gap = dense ? 0 : gap_len();
    if (gap < min_gap) gap = min_gap;
    if (gap > 0) begin
      pixel_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    pixel_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    int unsigned raw;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_IMAGE_WIDTH) begin
      raw = 32'(data[IMG_W_W-1:0]);
      eff_w = (raw < 3) ? 3 : ((raw > MAX_WIDTH) ? MAX_WIDTH : raw);
    end else begin
      raw = 32'(data[ROW_W-1:0]);
      eff_h = (raw < 3) ? 3 : raw;
    end
  endtask

  // The predicted frame position is registered in the scoreboard, so each pixel here is sent
  // with a nonzero minimum gap before the position is looked at.
  task automatic finish_frame();
    while (!frame_start) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0, 1);
  endtask

  initial begin
    int unsigned      run_left;
    int unsigned      stall_left;
    int               hold_ack;
    run_left = 0;
    stall_left = 0;
    hold_ack = 0;
    forever begin
      @(posedge clk_i);
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        run_left = 0;
        stall_left = HOLD_CYCLES;
      end
      if (run_left == 0 && stall_left == 0) begin
        run_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
        stall_left = gap_len();
      end
      if (run_left > 0) begin
        lbp_ready_i <= 1'b1;
        run_left--;
      end else begin
        lbp_ready_i <= 1'b0;
        stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lbp_3x3_pixel_stream_top test failed");
      $finish;
    end
  end

  initial begin
    int               sent;
    int               n;
    int               mode;
    int               phase;
    bit               dense;
    logic [PIX_W-1:0] base;
    int unsigned      w_raw;
    int unsigned      h_raw;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset geometry: a few codes of a full-size frame, then the frame is cut
    // short by shrinking both registers in mid-frame.
    for (int i = 0; i < 2 * eff_w + 5; i++) begin
      send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0, 0);
    end
    wait_idle();
    configure(REG_IMAGE_HEIGHT, CFG_W'(3));
    configure(REG_IMAGE_WIDTH, CFG_W'(8));
    finish_frame();
    wait_idle();

    configure(REG_IMAGE_WIDTH, CFG_W'(3));
    configure(REG_IMAGE_HEIGHT, CFG_W'(3));
    for (int i = 0; i < 9; i++) send_pixel(MIXED_FRAME[i[3:0]], 1'b0, 0);
    wait_idle();

    // Both values below the minimum are taken as three.
    configure(REG_IMAGE_WIDTH, CFG_W'(2));
    configure(REG_IMAGE_HEIGHT, CFG_W'(0));
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'hFF : 8'h00, 1'b0, 0);
    for (int i = 0; i < 9; i++) send_pixel(8'h80, 1'b1, 0);
    wait_idle();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      if (frame_start) begin
        case ($urandom_range(0, 19))
          0: w_raw = $urandom_range(0, 2);
          1, 2: w_raw = $urandom_range(41, 96);
          3, 4, 5, 6: w_raw = $urandom_range(13, 40);
          default: w_raw = $urandom_range(3, 12);
        endcase
        case ($urandom_range(0, 19))
          0: h_raw = $urandom_range(0, 2);
          1: h_raw = 16'hFFFF;
          2, 3, 4, 5: h_raw = $urandom_range(6, 12);
          default: h_raw = $urandom_range(3, 5);
        endcase
        configure(REG_IMAGE_WIDTH, CFG_W'(w_raw));
        configure(REG_IMAGE_HEIGHT, CFG_W'(h_raw));
      end else begin
        // In mid-frame the width only shrinks, so no line store entry is read
        // before the current frame has written it.
        if ($urandom_range(0, 1)) begin
          w_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, eff_w);
          configure(REG_IMAGE_WIDTH, CFG_W'(w_raw));
        end
        if (eff_h > 16 || $urandom_range(0, 1)) begin
          configure(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 8)));
        end
      end

      mode = $urandom_range(0, 3);
      base = PIX_W'($urandom_range(0, 255));
      dense = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 2 * eff_w * ((eff_h > 16) ? 4 : eff_h));
      if (n > 300) n = $urandom_range(100, 300);
      if (phase == 0) begin
        // From a frame start this dense run reaches two codes well within the
        // hold, so the output register fills and the pixel input stalls.
        hold_req <= hold_req + 1;
        dense = 1'b1;
        n = 2 * eff_w + 14;
      end else if (n > RANDOM_ITEMS - sent) begin
        n = RANDOM_ITEMS - sent;
      end

      for (int i = 0; i < n; i++) send_pixel(next_pixel(mode, base), dense, 0);
      sent += n;
      if (eff_h <= 16 && $urandom_range(0, 1)) finish_frame();
      phase++;
    end

    wait_idle();
    if (eff_h > 16) configure(REG_IMAGE_HEIGHT, CFG_W'(4));
    finish_frame();
    wait_idle();

    // Tallest frame, ended early by a height below the current row.
    configure(REG_IMAGE_WIDTH, CFG_W'(5));
    configure(REG_IMAGE_HEIGHT, 16'hFFFF);
    for (int i = 0; i < 4 * eff_w + 2; i++) begin
      send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0, 0);
    end
    wait_idle();
    configure(REG_IMAGE_HEIGHT, CFG_W'(2));
    finish_frame();
    wait_idle();

    if (error_count == 0) begin
      $display("lbp_3x3_pixel_stream_top test passed");
    end else begin
      $display("lbp_3x3_pixel_stream_top test failed");
    end
    $finish;
  end

endmodule
